FILE: rtl/mgvu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mgvu_pkg: shared constants and types for the grid velocity update
// Register indexes, field widths and the divider step type.
// ----------------------------------------------------------------------------
package mgvu_pkg;

  localparam int unsigned IdxW   = 18;
  localparam int unsigned MassW  = 31;
  localparam int unsigned VelW   = 32;
  localparam int unsigned CfgIdxW = 3;
  // dividend magnitude: |momentum| * 2^16 fits in 48 bits
  localparam int unsigned DivW   = 48;

  localparam int unsigned XCellsDef = 64;
  localparam int unsigned YCellsDef = 64;
  localparam int unsigned ZCellsDef = 64;

  localparam logic [CfgIdxW-1:0] RegOriginX  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOriginY  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOriginZ  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSizeX    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSizeY    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSizeZ    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMargin   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegGravity  = 3'd7;

  // one lane of the restoring divider as it travels down the pipe
  typedef struct packed {
    logic [DivW-1:0]  quo;   // remaining dividend bits shifting into quotient
    logic [MassW:0]   rem;   // partial remainder
    logic             neg;   // result sign
  } div_lane_t;

  // saturate a 34-bit signed sum to 32 bits
  function automatic logic signed [VelW-1:0] sat34(input logic signed [VelW+1:0] v);
    logic signed [VelW+1:0] hi;
    logic signed [VelW+1:0] lo;
    hi = 34'sd2147483647;
    lo = -34'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[VelW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mpm_grid_velocity_update_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpm_grid_velocity_update_core: grid node velocity update, one cell per cycle
// while the output does not stall. Items pass 12 divider stages plus
// index split, gravity, product, wall and output stages. Reset clears
// valid bits and loads default registers: origins 0, cell sizes 1.0,
// margin 0, gravity 0.
// ----------------------------------------------------------------------------
module mpm_grid_velocity_update_core
  import mgvu_pkg::*;
#(
  parameter int unsigned X_CELLS = XCellsDef,
  parameter int unsigned Y_CELLS = YCellsDef,
  parameter int unsigned Z_CELLS = ZCellsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [31:0]             cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [IdxW-1:0]         cell_index_i,
  input  wire logic [MassW-1:0]        cell_mass_i,
  input  wire logic signed [VelW-1:0]  momentum_x_i,
  input  wire logic signed [VelW-1:0]  momentum_y_i,
  input  wire logic signed [VelW-1:0]  momentum_z_i,
  input  wire logic signed [VelW-1:0]  prior_vel_x_i,
  input  wire logic signed [VelW-1:0]  prior_vel_y_i,
  input  wire logic signed [VelW-1:0]  prior_vel_z_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed [VelW-1:0]       new_vel_x_o,
  output logic signed [VelW-1:0]       new_vel_y_o,
  output logic signed [VelW-1:0]       new_vel_z_o,
  output logic                         occupied_o
);

  localparam int unsigned Plane = Y_CELLS * Z_CELLS;
  localparam int unsigned IxW   = IdxW;
  localparam int unsigned IyW   = $clog2(Y_CELLS + 1);
  localparam int unsigned IzW   = $clog2(Z_CELLS + 1);
  localparam int unsigned CW    = 52;  // centre and wall width
  localparam int unsigned SideW = IdxW + 1 + 3 * VelW;

  // reciprocal multipliers for the index split, exact for every index value
  localparam int unsigned PW    = 2 * IdxW + 4;
  localparam int unsigned ShP   = IdxW + $clog2(Plane);
  localparam int unsigned ShZ   = IdxW + $clog2(Z_CELLS);
  localparam logic [PW-1:0] MulP =
    PW'(((64'd1 << ShP) + 64'(Plane) - 64'd1) / 64'(Plane));
  localparam logic [PW-1:0] MulZ =
    PW'(((64'd1 << ShZ) + 64'(Z_CELLS) - 64'd1) / 64'(Z_CELLS));

  // configuration registers
  logic signed [31:0] org_x_q, org_y_q, org_z_q, grav_q;
  logic [30:0]        sz_x_q, sz_y_q, sz_z_q, margin_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0; org_y_q <= '0; org_z_q <= '0; grav_q <= '0;
      sz_x_q <= 31'd65536; sz_y_q <= 31'd65536; sz_z_q <= 31'd65536;
      margin_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegOriginX: org_x_q  <= cfg_data_i;
        RegOriginY: org_y_q  <= cfg_data_i;
        RegOriginZ: org_z_q  <= cfg_data_i;
        RegSizeX:   sz_x_q   <= cfg_data_i[30:0];
        RegSizeY:   sz_y_q   <= cfg_data_i[30:0];
        RegSizeZ:   sz_z_q   <= cfg_data_i[30:0];
        RegMargin:  margin_q <= cfg_data_i[30:0];
        RegGravity: grav_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // output skid: pipe advances unless the output register is full and stalled
  logic en;
  logic out_vld_q;
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // divider with the rest of the item riding alongside
  logic                   dv_vld;
  logic signed [VelW-1:0] qx, qy, qz;
  logic [SideW-1:0]       side_in, side_out;
  assign side_in = {cell_index_i, (cell_mass_i != '0),
                    prior_vel_x_i, prior_vel_y_i, prior_vel_z_i};

  mgvu_divider #(.SideW(SideW)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .mass_i(cell_mass_i),
    .num_x_i(momentum_x_i), .num_y_i(momentum_y_i), .num_z_i(momentum_z_i),
    .side_i(side_in), .valid_o(dv_vld),
    .quo_x_o(qx), .quo_y_o(qy), .quo_z_o(qz), .side_o(side_out)
  );

  logic [IdxW-1:0]        d_idx;
  logic                   d_occ;
  logic signed [VelW-1:0] d_px, d_py, d_pz;
  assign {d_idx, d_occ, d_px, d_py, d_pz} = side_out;

  // stage A: x index and index over z row length, velocity sums
  logic                   a_vld_q;
  logic                   a_occ_q;
  logic [IdxW-1:0]        a_idx_q;
  logic [IxW-1:0]         a_ix_q;
  logic [IdxW-1:0]        a_q2_q;
  logic signed [VelW-1:0] a_vx_q, a_vy_q, a_vz_q;
  logic [PW-1:0]          ix_prod, q2_prod;
  assign ix_prod = PW'(d_idx) * MulP;
  assign q2_prod = PW'(d_idx) * MulZ;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else if (en) a_vld_q <= dv_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_occ_q <= d_occ;
      a_idx_q <= d_idx;
      a_ix_q  <= IxW'(ix_prod >> ShP);
      a_q2_q  <= IdxW'(q2_prod >> ShZ);
      if (d_occ) begin
        a_vx_q <= sat34(34'(d_px) + 34'(qx));
        a_vy_q <= sat34(34'(d_py) + 34'(qy));
        a_vz_q <= sat34(34'(d_pz) + 34'(qz));
      end else begin
        a_vx_q <= d_px;
        a_vy_q <= d_py;
        a_vz_q <= d_pz;
      end
    end
  end

  // stage B: gravity, y and z indexes from the quotients
  logic                   b_vld_q, b_occ_q;
  logic signed [VelW-1:0] b_vx_q, b_vy_q, b_vz_q;
  logic [IxW-1:0]         b_ix_q;
  logic [IyW-1:0]         b_iy_q;
  logic [IzW-1:0]         b_iz_q;
  logic [PW-1:0]          ixy_prod, q2z_prod;
  assign ixy_prod = PW'(a_ix_q) * PW'(Y_CELLS);
  assign q2z_prod = PW'(a_q2_q) * PW'(Z_CELLS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else if (en) b_vld_q <= a_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_occ_q <= a_occ_q;
      b_vx_q  <= a_vx_q;
      b_vz_q  <= a_vz_q;
      b_vy_q  <= a_occ_q ? sat34(34'(a_vy_q) + 34'(grav_q)) : a_vy_q;
      b_ix_q  <= a_ix_q;
      b_iy_q  <= IyW'(a_q2_q - IdxW'(ixy_prod));
      b_iz_q  <= IzW'(a_idx_q - IdxW'(q2z_prod));
    end
  end

  // stage C: index times size products
  logic                   c_vld_q, c_occ_q;
  logic signed [VelW-1:0] c_vx_q, c_vy_q, c_vz_q;
  logic [CW-1:0]          c_px_q, c_py_q, c_pz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_vld_q <= 1'b0;
    else if (en) c_vld_q <= b_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_occ_q <= b_occ_q;
      c_vx_q  <= b_vx_q;
      c_vy_q  <= b_vy_q;
      c_vz_q  <= b_vz_q;
      c_px_q  <= CW'(b_ix_q) * CW'(sz_x_q);
      c_py_q  <= CW'(b_iy_q) * CW'(sz_y_q);
      c_pz_q  <= CW'(b_iz_q) * CW'(sz_z_q);
    end
  end

  // stage W: wall compares
  logic                   w_vld_q, w_occ_q, w_side_q, w_floor_q;
  logic signed [VelW-1:0] w_vx_q, w_vy_q, w_vz_q;
  logic signed [CW-1:0]   cx, cy, cz, wx, wy, wz, bm;
  assign cx = $signed(CW'(org_x_q)) + $signed(c_px_q) + $signed(CW'(sz_x_q[30:1]));
  assign cy = $signed(CW'(org_y_q)) + $signed(c_py_q) + $signed(CW'(sz_y_q[30:1]));
  assign cz = $signed(CW'(org_z_q)) + $signed(c_pz_q) + $signed(CW'(sz_z_q[30:1]));
  assign bm = $signed(CW'(margin_q));
  assign wx = $signed(CW'(X_CELLS) * CW'(sz_x_q)) - bm;
  assign wy = $signed(CW'(Y_CELLS) * CW'(sz_y_q)) - bm;
  assign wz = $signed(CW'(Z_CELLS) * CW'(sz_z_q)) - bm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) w_vld_q <= 1'b0;
    else if (en) w_vld_q <= c_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_occ_q   <= c_occ_q;
      w_vx_q    <= c_vx_q;
      w_vy_q    <= c_vy_q;
      w_vz_q    <= c_vz_q;
      w_side_q  <= (cx < bm) || (cx > wx) || (cz < bm) || (cz > wz) || (cy > wy);
      w_floor_q <= (cy < bm);
    end
  end

  // apply walls to occupied cells: side or top zeroes all, floor keeps only upward y, also after a side hit
  logic signed [VelW-1:0] vx_d, vy_d, vz_d;
  always_comb begin
    vx_d = w_vx_q;
    vy_d = w_vy_q;
    vz_d = w_vz_q;
    if (w_occ_q) begin
      if (w_side_q) begin
        vx_d = '0;
        vy_d = '0;
        vz_d = '0;
      end
      if (w_floor_q) begin
        vy_d = w_vy_q[VelW-1] ? '0 : w_vy_q;
      end
    end
  end

  // output register: hold until transfer
  logic                   out_occ_q;
  logic signed [VelW-1:0] out_vx_q, out_vy_q, out_vz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= w_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_occ_q <= w_occ_q;
      out_vx_q  <= vx_d;
      out_vy_q  <= vy_d;
      out_vz_q  <= vz_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign occupied_o  = out_occ_q;
  assign new_vel_x_o = out_vx_q;
  assign new_vel_y_o = out_vy_q;
  assign new_vel_z_o = out_vz_q;

endmodule

`default_nettype wire

FILE: rtl/mgvu_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mgvu_divider: pipelined restoring divider, three lanes
// Divides |momentum| * 2^16 by the mass, four quotient bits per stage,
// with a valid bit and a side payload moving alongside every stage.
// ----------------------------------------------------------------------------
module mgvu_divider
  import mgvu_pkg::*;
#(
  parameter int unsigned SideW = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire logic [MassW-1:0]        mass_i,
  input  wire logic signed [VelW-1:0]  num_x_i,
  input  wire logic signed [VelW-1:0]  num_y_i,
  input  wire logic signed [VelW-1:0]  num_z_i,
  input  wire logic [SideW-1:0]        side_i,
  output logic                         valid_o,
  output logic signed [VelW-1:0]       quo_x_o,
  output logic signed [VelW-1:0]       quo_y_o,
  output logic signed [VelW-1:0]       quo_z_o,
  output logic [SideW-1:0]             side_o
);

  localparam int unsigned BitsPerStage = 4;
  localparam int unsigned NStages      = DivW / BitsPerStage;

  div_lane_t                ld_lane [3];
  div_lane_t                lane_q [NStages][3];
  logic [MassW-1:0]         mass_q [NStages];
  logic [SideW-1:0]         side_q [NStages];
  logic                     vld_q  [NStages];

  // load: take magnitudes of each numerator
  always_comb begin
    logic signed [VelW-1:0] n [3];
    logic [VelW-1:0] mag;
    n[0] = num_x_i;
    n[1] = num_y_i;
    n[2] = num_z_i;
    for (int k = 0; k < 3; k++) begin
      mag = n[k][VelW-1] ? VelW'(-n[k]) : VelW'(n[k]);
      ld_lane[k].quo = {mag, 16'h0000};
      ld_lane[k].rem = '0;
      ld_lane[k].neg = n[k][VelW-1];
    end
  end

  // advance one stage: BitsPerStage restoring steps per lane
  for (genvar s = 0; s < NStages; s++) begin : g_stage
    div_lane_t        cur [3];
    div_lane_t        nxt [3];
    logic [MassW-1:0] cur_mass;
    logic [SideW-1:0] cur_side;
    logic             cur_vld;

    // stage input: the loaded item or the previous stage
    if (s == 0) begin : g_load
      assign cur      = ld_lane;
      assign cur_mass = mass_i;
      assign cur_side = side_i;
      assign cur_vld  = valid_i;
    end else begin : g_prev
      assign cur      = lane_q[s-1];
      assign cur_mass = mass_q[s-1];
      assign cur_side = side_q[s-1];
      assign cur_vld  = vld_q[s-1];
    end

    always_comb begin
      logic [MassW:0]   r;
      logic [DivW-1:0]  q;
      logic [MassW+1:0] t;
      for (int k = 0; k < 3; k++) begin
        r = cur[k].rem;
        q = cur[k].quo;
        for (int b = 0; b < BitsPerStage; b++) begin
          t = {r, q[DivW-1]} - {2'b00, cur_mass};
          if (!t[MassW+1]) begin
            r = t[MassW:0];
            q = {q[DivW-2:0], 1'b1};
          end else begin
            r = {r[MassW-1:0], q[DivW-1]};
            q = {q[DivW-2:0], 1'b0};
          end
        end
        nxt[k].quo = q;
        nxt[k].rem = r;
        nxt[k].neg = cur[k].neg;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lane_q[s] <= nxt;
        mass_q[s] <= cur_mass;
        side_q[s] <= cur_side;
      end
    end
  end

  // sign and saturate quotients
  always_comb begin
    logic signed [VelW-1:0] res [3];
    logic [DivW-1:0] m;
    for (int k = 0; k < 3; k++) begin
      m = lane_q[NStages-1][k].quo;
      if (lane_q[NStages-1][k].neg) begin
        res[k] = (m > DivW'(64'h80000000)) ? 32'sh80000000 : VelW'(-m);
      end else begin
        res[k] = (m > DivW'(64'h7fffffff)) ? 32'sh7fffffff : VelW'(m);
      end
    end
    quo_x_o = res[0];
    quo_y_o = res[1];
    quo_z_o = res[2];
  end

  assign valid_o = vld_q[NStages-1];
  assign side_o  = side_q[NStages-1];

endmodule

`default_nettype wire
